FILE: sv/ecft_pkg.sv
// Shared types and constants for the encoder frame position tracker.
package ecft_pkg;

  // Field and datapath widths
  localparam int RAW_W   = 24;
  localparam int POS_W   = 25;
  localparam int WIDE_W  = 26;
  localparam int SPD_W   = 32;
  localparam int US_W    = 32;
  localparam int SCALE_W = 18;
  localparam int DVD_W   = WIDE_W + SCALE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Frame header bytes
  localparam logic [7:0] HDR0 = 8'hFF;
  localparam logic [7:0] HDR1 = 8'h81;

  // us -> ms with 8 fraction bits: 1000 * 256
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 18'd256000;

  // Frame formats with special handling
  localparam logic [1:0] FMT_NEG   = 2'd1;
  localparam logic [1:0] FMT_SHORT = 2'd3;

  // Direction codes
  localparam logic [1:0] DIR_STILL = 2'd0;
  localparam logic [1:0] DIR_POS   = 2'd1;
  localparam logic [1:0] DIR_NEG   = 2'd2;

  // Reset values of the registers
  localparam logic [1:0]      RST_FORMAT = 2'd1;
  localparam logic [23:0]     RST_PPT    = 24'd65536;
  localparam logic [23:0]     RST_JLIM   = 24'd100;
  localparam logic [US_W-1:0] RST_WINDOW = 32'd60000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 3'd0,
    REG_ZERO   = 3'd1,
    REG_PPT    = 3'd2,
    REG_JLIM   = 3'd3,
    REG_WINDOW = 3'd4
  } cfg_idx_t;

  // Header hunt / byte collection phase
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_GOT_FF = 3'd1,
    PH_D0     = 3'd2,
    PH_D1     = 3'd3,
    PH_D2     = 3'd4,
    PH_CHK    = 3'd5
  } phase_t;

  // Frame processing sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_WRAP,
    ST_SIGN,
    ST_FILT,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_SAT,
    ST_DONE
  } seq_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/ecft_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ecft_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecft_pkg::div_ctl_t            ctl,
  input  logic [ecft_pkg::DVD_W-1:0]    dividend,
  input  logic [ecft_pkg::US_W-1:0]     divisor,
  output ecft_pkg::div_sts_t            sts,
  output logic [ecft_pkg::DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(ecft_pkg::DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(ecft_pkg::DVD_W);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [ecft_pkg::DVD_W-1:0] quo_r;
  logic [ecft_pkg::US_W-1:0]  rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ecft_pkg::US_W:0]    rem_sh;
  logic [ecft_pkg::US_W:0]    rem_sub;
  logic                       ge;

  // Shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[ecft_pkg::DVD_W-1]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LOAD;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[ecft_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[ecft_pkg::US_W-1:0] : rem_sh[ecft_pkg::US_W-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/encoder_frame_position_tracker_core.sv
// Serial encoder frame decoder with glitch-filtered position and Q8 speed.
// A tick or a byte that does not end a good frame leaves the input ready for the next word.
// A good frame runs through the diff, wrap, sign and filter steps and, with a speed update,
// the multiply and the 44-step bit-serial divider before its result word is loaded; no input
// word is taken meanwhile, and a result word not yet taken holds the load back.
// Synchronous active-low reset initialises control, config and tracker state, not the datapath.
module encoder_frame_position_tracker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [7:0]                         in_rx_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ecft_pkg::RAW_W-1:0]         out_raw_value,
  output logic signed [ecft_pkg::POS_W-1:0]  out_position,
  output logic signed [ecft_pkg::SPD_W-1:0]  out_speed_q8,
  output logic                               out_speed_updated,
  output logic [1:0]                         out_direction,
  // configuration
  input  logic                               cfg_we,
  input  logic [ecft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int POS_W  = ecft_pkg::POS_W;
  localparam int WIDE_W = ecft_pkg::WIDE_W;
  localparam int DVD_W  = ecft_pkg::DVD_W;
  localparam int SPD_W  = ecft_pkg::SPD_W;
  localparam int US_W   = ecft_pkg::US_W;
  localparam logic [US_W-1:0] US_MAX = '1;
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h8000_0000);
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h7FFF_FFFF);

  // Configuration registers
  logic [1:0]      fmt_r;
  logic [23:0]     zoff_r;
  logic [23:0]     ppt_r;
  logic [23:0]     jlim_r;
  logic [US_W-1:0] win_r;

  // Hunt and tracker state
  ecft_pkg::phase_t            phase_r;
  logic [23:0]                 value_r;
  logic [7:0]                  sum_r;
  logic                        started_r;
  logic signed [POS_W-1:0]     held_r;
  logic signed [POS_W-1:0]     wstart_r;
  logic [US_W-1:0]             elapsed_r;
  logic signed [SPD_W-1:0]     speed_r;

  // Sequencer
  ecft_pkg::seq_t state_r, state_nxt;

  // Frame datapath
  logic signed [POS_W-1:0]  diff_r;
  logic signed [WIDE_W-1:0] wrap_r;
  logic signed [POS_W-1:0]  pos_r;
  logic signed [WIDE_W-1:0] delta_r;
  logic                     neg_r;
  logic                     upd_r;
  logic [DVD_W-1:0]         dividend_r;

  // Output register
  logic                     out_valid_r;
  logic [23:0]              o_raw_r;
  logic signed [POS_W-1:0]  o_pos_r;
  logic signed [SPD_W-1:0]  o_spd_r;
  logic                     o_upd_r;
  logic [1:0]               o_dir_r;

  // Divider link
  ecft_pkg::div_ctl_t div_ctl;
  ecft_pkg::div_sts_t div_sts;
  logic [DVD_W-1:0]   quotient;

  // Combinational helpers
  logic                     in_acc;
  logic                     byte_acc;
  logic                     frame_ok;
  logic                     out_load;
  logic [POS_W-1:0]         diff_mag;
  logic                     wrap_gt;
  logic signed [WIDE_W-1:0] diff_w;
  logic signed [WIDE_W-1:0] ppt_w;
  logic signed [WIDE_W-1:0] sign_w;
  logic signed [WIDE_W-1:0] jump_w;
  logic [WIDE_W-1:0]        jump_mag;
  logic                     jump_ok;
  logic [WIDE_W-1:0]        delta_mag;
  logic [DVD_W-1:0]         product;
  logic [1:0]               dir_c;

  assign in_ready = (state_r == ecft_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign byte_acc = in_acc && !in_mode;
  assign frame_ok = byte_acc && (phase_r == ecft_pkg::PH_CHK) && (in_rx_byte == sum_r);
  assign out_load = (state_r == ecft_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Wrap by half a revolution
  always_comb begin
    diff_w   = {diff_r[POS_W-1], diff_r};
    ppt_w    = {2'b00, ppt_r};
    diff_mag = diff_r[POS_W-1] ? -diff_r : diff_r;
    wrap_gt  = (diff_mag > {2'b00, ppt_r[23:1]});
  end

  // Sign, filter and speed delta helpers
  always_comb begin
    sign_w    = (fmt_r == ecft_pkg::FMT_NEG) ? -wrap_r : wrap_r;
    jump_w    = {held_r[POS_W-1], held_r} - {pos_r[POS_W-1], pos_r};
    jump_mag  = jump_w[WIDE_W-1] ? -jump_w : jump_w;
    jump_ok   = (jump_mag < {2'b00, jlim_r});
    delta_mag = delta_r[WIDE_W-1] ? -delta_r : delta_r;
    product   = {{(DVD_W-WIDE_W){1'b0}}, delta_mag}
              * {{(DVD_W-ecft_pkg::SCALE_W){1'b0}}, ecft_pkg::SPEED_SCALE};
  end

  // Direction from stored speed
  always_comb begin
    if (speed_r > 0) begin
      dir_c = ecft_pkg::DIR_POS;
    end else if (speed_r < 0) begin
      dir_c = ecft_pkg::DIR_NEG;
    end else begin
      dir_c = ecft_pkg::DIR_STILL;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and divider start
  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    unique case (state_r)
      ecft_pkg::ST_IDLE:   if (frame_ok) state_nxt = ecft_pkg::ST_DIFF;
      ecft_pkg::ST_DIFF:   state_nxt = ecft_pkg::ST_WRAP;
      ecft_pkg::ST_WRAP:   state_nxt = ecft_pkg::ST_SIGN;
      ecft_pkg::ST_SIGN:   state_nxt = ecft_pkg::ST_FILT;
      ecft_pkg::ST_FILT: begin
        if (started_r && (elapsed_r > win_r)) begin
          state_nxt = ecft_pkg::ST_MUL;
        end else begin
          state_nxt = ecft_pkg::ST_DONE;
        end
      end
      ecft_pkg::ST_MUL:    state_nxt = ecft_pkg::ST_DSTART;
      ecft_pkg::ST_DSTART: begin
        div_ctl.start = 1'b1;
        state_nxt     = ecft_pkg::ST_DIV;
      end
      ecft_pkg::ST_DIV:    if (div_sts.done) state_nxt = ecft_pkg::ST_SAT;
      ecft_pkg::ST_SAT:    state_nxt = ecft_pkg::ST_DONE;
      ecft_pkg::ST_DONE:   if (out_load) state_nxt = ecft_pkg::ST_IDLE;
      default:             state_nxt = ecft_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= ecft_pkg::RST_FORMAT;
      zoff_r <= '0;
      ppt_r  <= ecft_pkg::RST_PPT;
      jlim_r <= ecft_pkg::RST_JLIM;
      win_r  <= ecft_pkg::RST_WINDOW;
    end else if (cfg_we) begin
      unique case (ecft_pkg::cfg_idx_t'(cfg_index))
        ecft_pkg::REG_FORMAT: fmt_r  <= cfg_wdata[1:0];
        ecft_pkg::REG_ZERO:   zoff_r <= cfg_wdata[23:0];
        ecft_pkg::REG_PPT:    ppt_r  <= cfg_wdata[23:0];
        ecft_pkg::REG_JLIM:   jlim_r <= cfg_wdata[23:0];
        ecft_pkg::REG_WINDOW: win_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Header hunt, byte collection and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ecft_pkg::PH_HUNT;
      value_r <= '0;
      sum_r   <= '0;
    end else if (byte_acc) begin
      unique case (phase_r)
        ecft_pkg::PH_GOT_FF: begin
          if (in_rx_byte == ecft_pkg::HDR1) begin
            phase_r <= ecft_pkg::PH_D0;
            value_r <= '0;
            sum_r   <= ecft_pkg::HDR0 + ecft_pkg::HDR1;
          end else if (in_rx_byte != ecft_pkg::HDR0) begin
            phase_r <= ecft_pkg::PH_HUNT;
          end
        end
        ecft_pkg::PH_D0, ecft_pkg::PH_D1, ecft_pkg::PH_D2: begin
          value_r <= {value_r[15:0], in_rx_byte};
          sum_r   <= sum_r + in_rx_byte;
          if (phase_r == ecft_pkg::PH_D0) begin
            phase_r <= ecft_pkg::PH_D1;
          end else if (phase_r == ecft_pkg::PH_D1) begin
            phase_r <= (fmt_r == ecft_pkg::FMT_SHORT) ? ecft_pkg::PH_CHK : ecft_pkg::PH_D2;
          end else begin
            phase_r <= ecft_pkg::PH_CHK;
          end
        end
        ecft_pkg::PH_CHK: phase_r <= ecft_pkg::PH_HUNT;
        default: begin
          phase_r <= (in_rx_byte == ecft_pkg::HDR0) ? ecft_pkg::PH_GOT_FF : ecft_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Tracker state: tick count, filter, speed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      held_r    <= '0;
      wstart_r  <= '0;
      elapsed_r <= '0;
      speed_r   <= '0;
      upd_r     <= 1'b0;
    end else begin
      if (in_acc && in_mode && (elapsed_r != US_MAX)) begin
        elapsed_r <= elapsed_r + 1'b1;
      end
      if (state_r == ecft_pkg::ST_FILT) begin
        upd_r <= started_r && (elapsed_r > win_r);
        if (!started_r) begin
          held_r    <= pos_r;
          wstart_r  <= pos_r;
          elapsed_r <= '0;
          started_r <= 1'b1;
        end else if (jump_ok) begin
          held_r <= pos_r;
        end
      end
      if (state_r == ecft_pkg::ST_SAT) begin
        elapsed_r <= '0;
        wstart_r  <= pos_r;
        if (neg_r) begin
          speed_r <= (quotient > NEG_LIM) ? $signed(NEG_LIM[SPD_W-1:0])
                                          : -$signed(quotient[SPD_W-1:0]);
        end else begin
          speed_r <= (quotient > POS_LIM) ? $signed(POS_LIM[SPD_W-1:0])
                                          : $signed(quotient[SPD_W-1:0]);
        end
      end
    end
  end

  // Frame datapath steps
  always_ff @(posedge clk) begin
    unique case (state_r)
      ecft_pkg::ST_DIFF: diff_r <= $signed({1'b0, value_r} - {1'b0, zoff_r});
      ecft_pkg::ST_WRAP: begin
        if (wrap_gt && diff_r[POS_W-1]) begin
          wrap_r <= diff_w + ppt_w;
        end else if (wrap_gt) begin
          wrap_r <= diff_w - ppt_w;
        end else begin
          wrap_r <= diff_w;
        end
      end
      ecft_pkg::ST_SIGN: pos_r <= sign_w[POS_W-1:0];
      ecft_pkg::ST_FILT: delta_r <= {pos_r[POS_W-1], pos_r} - {wstart_r[POS_W-1], wstart_r};
      ecft_pkg::ST_MUL: begin
        neg_r      <= delta_r[WIDE_W-1];
        dividend_r <= product;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_raw_r <= value_r;
      o_pos_r <= held_r;
      o_spd_r <= speed_r;
      o_upd_r <= upd_r;
      o_dir_r <= dir_c;
    end
  end

  // Speed divider
  ecft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (dividend_r),
    .divisor  (elapsed_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign out_valid         = out_valid_r;
  assign out_raw_value     = o_raw_r;
  assign out_position      = o_pos_r;
  assign out_speed_q8      = o_spd_r;
  assign out_speed_updated = o_upd_r;
  assign out_direction     = o_dir_r;

endmodule

FILE: dv/ecft_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the encoder frame tracker: tracks frames, predicts and compares words.
module ecft_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_mode,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ecft_pkg::RAW_W-1:0]        out_raw_value,
  input  logic signed [ecft_pkg::POS_W-1:0] out_position,
  input  logic signed [ecft_pkg::SPD_W-1:0] out_speed_q8,
  input  logic                              out_speed_updated,
  input  logic [1:0]                        out_direction,
  input  logic                              cfg_we,
  input  logic [ecft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecft_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                err_count,
  output int                                pending
);

  typedef struct packed {
    logic [ecft_pkg::RAW_W-1:0]        raw;
    logic signed [ecft_pkg::POS_W-1:0] pos;
    logic signed [ecft_pkg::SPD_W-1:0] spd;
    logic                              upd;
    logic [1:0]                        dir;
  } frame_result_t;

  frame_result_t frame_results_q[$];
  int errs = 0;

  // Register copies
  logic [1:0]                fmt;
  logic [23:0]               zoff;
  logic [23:0]               ppt;
  logic [23:0]               jlim;
  logic [ecft_pkg::US_W-1:0] win;

  // Tracker state
  ecft_pkg::phase_t          hunt;
  logic [23:0]               shift;
  logic [7:0]                csum;
  bit                        started;
  longint                    held;
  longint                    win_start;
  logic [ecft_pkg::US_W-1:0] elapsed;
  longint                    speed;

  // Offset, half-turn wrap and optional negation
  function automatic longint frame_position(input logic [23:0] raw);
    longint diff, half, mag, pos;
    diff = longint'(raw) - longint'(zoff);
    half = longint'(ppt) / 2;
    mag  = (diff < 0) ? -diff : diff;
    pos  = diff;
    if (mag > half && diff > 0)
      pos = diff - longint'(ppt);
    else if (mag > half && diff < 0)
      pos = diff + longint'(ppt);
    if (fmt == ecft_pkg::FMT_NEG)
      pos = -pos;
    return pos;
  endfunction

  // Q8 pulses per ms, truncated toward zero, saturated to 32 bits signed
  function automatic longint q8_speed(input longint delta,
                                      input logic [ecft_pkg::US_W-1:0] us);
    longint num, mag, q;
    num = delta * longint'(ecft_pkg::SPEED_SCALE);
    mag = (num < 0) ? -num : num;
    q   = mag / longint'(us);
    if (num < 0) begin
      if (q > 64'sh8000_0000)
        q = 64'sh8000_0000;
      return -q;
    end
    if (q > 64'sh7FFF_FFFF)
      q = 64'sh7FFF_FFFF;
    return q;
  endfunction

  // Good frame: filter, maybe recompute speed, queue the expected word
  task automatic take_frame(input logic [23:0] raw);
    longint pos, jump;
    frame_result_t r;
    pos = frame_position(raw);
    if (!started) begin
      held      = pos;
      win_start = pos;
      elapsed   = '0;
      started   = 1'b1;
    end
    jump = held - pos;
    if (jump < 0)
      jump = -jump;
    if (jump < longint'(jlim))
      held = pos;
    r.upd = 1'b0;
    if (elapsed > win) begin
      speed     = q8_speed(pos - win_start, elapsed);
      elapsed   = '0;
      win_start = pos;
      r.upd     = 1'b1;
    end
    r.raw = raw;
    r.pos = ecft_pkg::POS_W'(held);
    r.spd = ecft_pkg::SPD_W'(speed);
    r.dir = (speed > 0) ? ecft_pkg::DIR_POS
                        : ((speed < 0) ? ecft_pkg::DIR_NEG : ecft_pkg::DIR_STILL);
    frame_results_q.push_back(r);
  endtask

  // One accepted input word: tick or received byte
  task automatic take_word(input logic mode, input logic [7:0] b);
    if (mode) begin
      if (elapsed != '1)
        elapsed++;
    end else begin
      case (hunt)
        ecft_pkg::PH_GOT_FF: begin
          if (b == ecft_pkg::HDR1) begin
            hunt  = ecft_pkg::PH_D0;
            shift = '0;
            csum  = ecft_pkg::HDR0 + ecft_pkg::HDR1;
          end else if (b != ecft_pkg::HDR0) begin
            hunt = ecft_pkg::PH_HUNT;
          end
        end
        ecft_pkg::PH_D0, ecft_pkg::PH_D1, ecft_pkg::PH_D2: begin
          shift = {shift[15:0], b};
          csum  = csum + b;
          if (hunt == ecft_pkg::PH_D0)
            hunt = ecft_pkg::PH_D1;
          else if (hunt == ecft_pkg::PH_D1)
            hunt = (fmt == ecft_pkg::FMT_SHORT) ? ecft_pkg::PH_CHK : ecft_pkg::PH_D2;
          else
            hunt = ecft_pkg::PH_CHK;
        end
        ecft_pkg::PH_CHK: begin
          hunt = ecft_pkg::PH_HUNT;
          if (b == csum)
            take_frame(shift);
        end
        default: hunt = (b == ecft_pkg::HDR0) ? ecft_pkg::PH_GOT_FF : ecft_pkg::PH_HUNT;
      endcase
    end
  endtask

  // Compare one result word against the oldest expectation
  task automatic check_result();
    frame_result_t want;
    if (frame_results_q.size() == 0) begin
      errs++;
      $display("%0t: expected no word, actual raw_value %h position %0d", $time,
               out_raw_value, out_position);
    end else begin
      want = frame_results_q.pop_front();
      if (want.raw !== out_raw_value) begin
        errs++;
        $display("%0t: raw_value expected %h actual %h", $time, want.raw, out_raw_value);
      end
      if (want.pos !== out_position) begin
        errs++;
        $display("%0t: position expected %0d actual %0d", $time, want.pos, out_position);
      end
      if (want.spd !== out_speed_q8) begin
        errs++;
        $display("%0t: speed_q8 expected %0d actual %0d", $time, want.spd, out_speed_q8);
      end
      if (want.upd !== out_speed_updated) begin
        errs++;
        $display("%0t: speed_updated expected %b actual %b", $time, want.upd,
                 out_speed_updated);
      end
      if (want.dir !== out_direction) begin
        errs++;
        $display("%0t: direction expected %0d actual %0d", $time, want.dir, out_direction);
      end
    end
  endtask

  // Watch config writes, accepted input words and result words
  always @(posedge clk) begin
    if (!rst_n) begin
      fmt       = ecft_pkg::RST_FORMAT;
      zoff      = '0;
      ppt       = ecft_pkg::RST_PPT;
      jlim      = ecft_pkg::RST_JLIM;
      win       = ecft_pkg::RST_WINDOW;
      hunt      = ecft_pkg::PH_HUNT;
      shift     = '0;
      csum      = '0;
      started   = 1'b0;
      held      = 0;
      win_start = 0;
      elapsed   = '0;
      speed     = 0;
      frame_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ecft_pkg::REG_FORMAT: fmt  = cfg_wdata[1:0];
          ecft_pkg::REG_ZERO:   zoff = cfg_wdata[23:0];
          ecft_pkg::REG_PPT:    ppt  = cfg_wdata[23:0];
          ecft_pkg::REG_JLIM:   jlim = cfg_wdata[23:0];
          ecft_pkg::REG_WINDOW: win  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        take_word(in_mode, in_rx_byte);
      if (out_valid && out_ready)
        check_result();
    end
    pending   <= frame_results_q.size();
    err_count <= errs;
  end

endmodule

FILE: dv/tb_encoder_frame_position_tracker_core.sv
`timescale 1ns / 1ps
// Testbench top for the encoder frame tracker: stimulus, config phases and verdict.
module tb_encoder_frame_position_tracker_core;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 115;
  localparam int DRAIN_CYCLES    = 60;

  // Formats without a package name, and an index that maps to no register
  localparam logic [1:0]                     FMT_ZERO  = 2'd0;
  localparam logic [1:0]                     FMT_PLAIN = 2'd2;
  localparam logic [ecft_pkg::CFG_IDX_W-1:0] IDX_SPARE = 3'd7;

  logic                              clk;
  logic                              rst_n       = 1'b0;
  logic                              in_valid    = 1'b0;
  logic                              in_ready;
  logic                              in_mode     = 1'b0;
  logic [7:0]                        in_rx_byte  = 8'h00;
  logic                              out_valid;
  logic                              out_ready   = 1'b0;
  logic [ecft_pkg::RAW_W-1:0]        out_raw_value;
  logic signed [ecft_pkg::POS_W-1:0] out_position;
  logic signed [ecft_pkg::SPD_W-1:0] out_speed_q8;
  logic                              out_speed_updated;
  logic [1:0]                        out_direction;
  logic                              cfg_we      = 1'b0;
  logic [ecft_pkg::CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [ecft_pkg::CFG_DATA_W-1:0]   cfg_wdata   = '0;

  int          err_count;
  int          pending;
  int          cycles   = 0;
  bit          idle_on  = 1'b1;
  logic [1:0]  cur_fmt  = ecft_pkg::RST_FORMAT;
  logic [23:0] cur_zoff = '0;
  logic [23:0] last_raw = '0;

  encoder_frame_position_tracker_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_value     (out_raw_value),
    .out_position      (out_position),
    .out_speed_q8      (out_speed_q8),
    .out_speed_updated (out_speed_updated),
    .out_direction     (out_direction),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  ecft_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_value     (out_raw_value),
    .out_position      (out_position),
    .out_speed_q8      (out_speed_q8),
    .out_speed_updated (out_speed_updated),
    .out_direction     (out_direction),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .err_count         (err_count),
    .pending           (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stall before each word while idle gaps are on
  initial begin
    int gap;
    forever begin
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input word; valid stays up across back-to-back words
  task automatic send_word(input logic mode, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(1'b1, 8'($urandom));
  endtask

  // Full frame at the current format, ticks sprinkled between bytes
  task automatic send_frame(input logic [23:0] raw, input bit good);
    int nb;
    logic [7:0] csum;
    logic [7:0] b;
    nb   = (cur_fmt == ecft_pkg::FMT_SHORT) ? 2 : 3;
    csum = ecft_pkg::HDR0 + ecft_pkg::HDR1;
    if ($urandom_range(0, 9) == 0)
      send_word(1'b0, ecft_pkg::HDR0);
    send_word(1'b0, ecft_pkg::HDR0);
    if ($urandom_range(0, 3) == 0)
      send_ticks($urandom_range(1, 3));
    send_word(1'b0, ecft_pkg::HDR1);
    for (int i = nb - 1; i >= 0; i--) begin
      b    = raw[8*i +: 8];
      csum = csum + b;
      if ($urandom_range(0, 3) == 0)
        send_ticks($urandom_range(1, 3));
      send_word(1'b0, b);
    end
    if (!good)
      csum = csum ^ 8'($urandom_range(1, 255));
    send_word(1'b0, csum);
  endtask

  // Stop sending and wait until every expected word is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ecft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ecft_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [1:0] f, input logic [23:0] z, input logic [23:0] p,
                              input logic [23:0] j, input logic [ecft_pkg::US_W-1:0] w);
    write_reg(ecft_pkg::REG_FORMAT, ecft_pkg::CFG_DATA_W'(f));
    write_reg(ecft_pkg::REG_ZERO, ecft_pkg::CFG_DATA_W'(z));
    write_reg(ecft_pkg::REG_PPT, ecft_pkg::CFG_DATA_W'(p));
    write_reg(ecft_pkg::REG_JLIM, ecft_pkg::CFG_DATA_W'(j));
    write_reg(ecft_pkg::REG_WINDOW, w);
    write_reg(IDX_SPARE, $urandom);
    cfg_we   <= 1'b0;
    cur_fmt  = f;
    cur_zoff = z;
  endtask

  // Main stimulus
  initial begin
    int pick, n, sent;
    logic [23:0] raw, ppt_pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise, hunt restart, repeated FF, extremes, bad checksum
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, ecft_pkg::HDR0);
    send_word(1'b0, 8'h00);
    send_word(1'b0, ecft_pkg::HDR0);
    send_frame(24'hFFFFFF, 1'b1);
    send_frame(24'h000000, 1'b0);
    send_frame(24'h000001, 1'b1);

    // Directed: format switched to short between the first and second data byte
    drain();
    program_regs(FMT_PLAIN, 24'd0, ecft_pkg::RST_PPT, ecft_pkg::RST_JLIM,
                 ecft_pkg::RST_WINDOW);
    send_word(1'b0, ecft_pkg::HDR0);
    send_word(1'b0, ecft_pkg::HDR1);
    send_word(1'b0, 8'h12);
    drain();
    write_reg(ecft_pkg::REG_FORMAT, ecft_pkg::CFG_DATA_W'(ecft_pkg::FMT_SHORT));
    cfg_we  <= 1'b0;
    cur_fmt = ecft_pkg::FMT_SHORT;
    send_word(1'b0, 8'h34);
    send_word(1'b0, 8'(ecft_pkg::HDR0 + ecft_pkg::HDR1 + 8'h12 + 8'h34));

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = (p % 3) != 2;
      drain();
      case ($urandom_range(0, 2))
        0:       ppt_pick = 24'($urandom_range(1, 4096));
        1:       ppt_pick = 24'($urandom);
        default: ppt_pick = ecft_pkg::RST_PPT;
      endcase
      case (p)
        0: program_regs(ecft_pkg::FMT_NEG, 24'd0, ecft_pkg::RST_PPT, ecft_pkg::RST_JLIM,
                        32'd0);
        1: program_regs(FMT_PLAIN, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'd1);
        2: program_regs(ecft_pkg::FMT_SHORT, 24'($urandom), 24'd0, 24'd0, 32'd5);
        3: program_regs(FMT_ZERO, 24'($urandom), 24'd1, 24'd500, 32'hFFFF_FFFF);
        default: program_regs(2'($urandom_range(0, 3)), 24'($urandom), ppt_pick,
                              24'($urandom_range(0, 3000)), 32'($urandom_range(0, 40)));
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // mostly small steps so the glitch filter lets them through
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: raw = last_raw + 24'($urandom_range(0, 600)) - 24'd300;
            6, 7:             raw = cur_zoff + 24'($urandom_range(0, 200)) - 24'd100;
            8:                raw = 24'($urandom);
            default:          raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
          endcase
          last_raw = raw;
          send_frame(raw, $urandom_range(0, 9) != 0);
          sent += 6;
        end else if (pick < 90) begin
          n = $urandom_range(1, 8);
          send_ticks(n);
          sent += n;
        end else begin
          // noise and partial headers
          repeat ($urandom_range(1, 4))
            send_word(1'b0, $urandom_range(0, 1) ? ecft_pkg::HDR0 : 8'($urandom));
        end
      end
    end

    drain();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
